@@ hdl/htd_pkg.sv @@
// Shared types and constants of the Huffman code-tree decoder.
// No dependencies; imported by huffman_tree_decoder.

package htd_pkg;

    localparam int NODE_COUNT   = 512;
    localparam int MAX_CODE_LEN = 32;
    localparam int NODE_AW      = $clog2(NODE_COUNT);
    localparam int FREE_W       = $clog2(NODE_COUNT + 1);
    localparam int CODE_W       = 32;
    localparam int POS_W        = $clog2(CODE_W);
    localparam int CNT_W        = 32;
    localparam int SYM_W        = 8;

    // item opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [SYM_W-1:0] entry_symbol;
        logic [5:0]       code_length;
        logic [31:0]      code_value;
        logic [7:0]       data_byte;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0] decoded_symbol;
        logic [1:0]       status;
        logic             last;
        logic             stream_done;
    } t_out_item;

    typedef struct packed {
        logic [NODE_AW-1:0] zero_child;
        logic [NODE_AW-1:0] one_child;
        logic [SYM_W-1:0]   symbol;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_LD_RD,
        S_LD_CHK,
        S_LD_NEW,
        S_LD_LEAF,
        S_DEC_RD,
        S_DEC_CHK,
        S_DEC_LEAF,
        S_DEC_FLUSH
    } t_state;

endpackage

@@ hdl/htd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/huffman_tree_decoder.sv @@
// Huffman code-tree decoder: top level with sequencer and node memory.
// Depends on htd_pkg and htd_ram.
//
// Items go in on i_item and transfer when start is high and busy is low:
// load inserts one code (symbol, length, right-aligned bits), data feeds one
// byte (MSB first), clear empties the tree and loads the symbol counter from
// symbols_expected, written on i_cfg_valid / o_cfg_ready / i_cfg_data (ready
// is always high; write it only while idle). Each result sits on o_result
// for one cycle with o_res_strobe high; the receiver cannot stall, so every
// strobe is a transfer. last marks the final result of an item.
// One node RAM with a registered read serves every tree step. After the
// transfer a data byte holds busy through a read state, a check state per
// bit that misses or check and leaf states per bit that descends, and a
// flush state; the last expected symbol can end the byte early. A load
// holds busy through a read state, a check per existing inner node, check,
// new-node and read states per new inner node, and check and leaf states
// for the leaf. Clear, a bad length, an unused opcode and a byte after the
// stream ended leave busy low. A reject strobes the next cycle; a decoded
// or absent-branch result waits for the next result of its byte or the
// flush state and strobes the cycle after that. The next item can transfer
// in the first cycle with busy low. After reset the block clears the root
// (busy high), then idles with an empty tree and a symbol count of zero.

module huffman_tree_decoder (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  htd_pkg::t_in_item       i_item,
    output logic                    busy,
    output logic                    o_res_strobe,
    output htd_pkg::t_out_item      o_result,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [htd_pkg::CNT_W-1:0] i_cfg_data
);

    import htd_pkg::*;

    // sequencer
    t_state r_state, n_state;

    // load walk
    logic [NODE_AW-1:0] r_node, n_node;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [CODE_W-1:0]  r_code, n_code;
    logic [SYM_W-1:0]   r_sym, n_sym;

    // decode walk
    logic [7:0]         r_byte, n_byte;
    logic [2:0]         r_bit, n_bit;
    logic [NODE_AW-1:0] r_cur, n_cur;

    // tree and stream bookkeeping
    logic [FREE_W-1:0]  r_free, n_free;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [CNT_W-1:0]   r_expected, n_expected;

    // one result is held back until we know whether it is the last one
    t_out_item          r_pend, n_pend;
    logic               r_pend_vld, n_pend_vld;
    t_out_item          r_out, n_out;
    logic               r_out_vld, n_out_vld;

    // node RAM port
    logic               ram_we;
    logic [NODE_AW-1:0] ram_waddr;
    t_node              ram_wdata;
    logic [NODE_AW-1:0] ram_raddr;
    logic [NODE_W-1:0]  ram_rdata;
    t_node              rd_node;

    // sequencer outputs
    logic               res_fire;
    t_out_item          res_item;
    logic               rej_fire;

    // decoded conditions
    logic               accept;
    logic               len_bad;
    logic               ld_bit;
    logic [NODE_AW-1:0] ld_slot;
    logic               ld_follow;
    logic               mem_full;
    logic [NODE_AW-1:0] free_addr;
    logic               dec_bit;
    logic [NODE_AW-1:0] dec_next;
    logic               is_leaf;
    logic               last_symbol;

    htd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_node     = ram_rdata;
    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign len_bad   = (i_item.code_length == 6'd0)
                    || (i_item.code_length > 6'(MAX_CODE_LEN));
    assign ld_bit    = r_code[r_pos];
    assign ld_slot   = ld_bit ? rd_node.one_child : rd_node.zero_child;
    // walk down an existing branch above the final code bit
    assign ld_follow = (r_pos != '0) && (ld_slot != '0);
    assign mem_full  = (r_free == FREE_W'(NODE_COUNT));
    assign free_addr = r_free[NODE_AW-1:0];

    assign dec_bit     = r_byte[r_bit];
    assign dec_next    = dec_bit ? rd_node.one_child : rd_node.zero_child;
    assign is_leaf     = (rd_node.zero_child == '0) && (rd_node.one_child == '0);
    assign last_symbol = (r_left == CNT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_item.opcode == OP_LOAD && !len_bad) begin
                        n_state = S_LD_RD;
                    end else if (i_item.opcode == OP_DATA && r_left != '0) begin
                        n_state = S_DEC_RD;
                    end
                end
            end
            S_LD_RD: begin
                n_state = S_LD_CHK;
            end
            S_LD_CHK: begin
                if (ld_follow) begin
                    n_state = S_LD_CHK;
                end else if (mem_full) begin
                    n_state = S_IDLE;
                end else if (r_pos != '0) begin
                    n_state = S_LD_NEW;
                end else begin
                    n_state = S_LD_LEAF;
                end
            end
            S_LD_NEW: begin
                n_state = S_LD_RD;
            end
            S_LD_LEAF: begin
                n_state = S_IDLE;
            end
            S_DEC_RD: begin
                n_state = S_DEC_CHK;
            end
            S_DEC_CHK: begin
                if (dec_next != '0) begin
                    n_state = S_DEC_LEAF;
                end else if (r_bit == 3'd0) begin
                    n_state = S_DEC_FLUSH;
                end else begin
                    n_state = S_DEC_CHK;
                end
            end
            S_DEC_LEAF: begin
                if (r_bit == 3'd0 || (is_leaf && last_symbol)) begin
                    n_state = S_DEC_FLUSH;
                end else begin
                    n_state = S_DEC_CHK;
                end
            end
            S_DEC_FLUSH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer outputs: RAM port and result events
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = r_cur;
        res_fire  = 1'b0;
        res_item  = '0;
        rej_fire  = 1'b0;
        case (r_state)
            S_INIT: begin
                // clear the root
                ram_we = 1'b1;
            end
            S_IDLE: begin
                if (accept && i_item.opcode == OP_CLEAR) begin
                    ram_we = 1'b1;
                end
                if (accept && i_item.opcode == OP_LOAD && len_bad) begin
                    rej_fire = 1'b1;
                end
            end
            S_LD_RD: begin
                ram_raddr = r_node;
            end
            S_LD_CHK: begin
                if (ld_follow) begin
                    ram_raddr = ld_slot;
                end else if (mem_full) begin
                    rej_fire = 1'b1;
                end else begin
                    // hang the fresh node on the parent; an old child is dropped
                    ram_we    = 1'b1;
                    ram_waddr = r_node;
                    ram_wdata = rd_node;
                    if (ld_bit) begin
                        ram_wdata.one_child = free_addr;
                    end else begin
                        ram_wdata.zero_child = free_addr;
                    end
                end
            end
            S_LD_NEW: begin
                ram_we    = 1'b1;
                ram_waddr = r_node;
            end
            S_LD_LEAF: begin
                ram_we           = 1'b1;
                ram_waddr        = r_node;
                ram_wdata.symbol = r_sym;
            end
            S_DEC_RD: begin
                ram_raddr = r_cur;
            end
            S_DEC_CHK: begin
                if (dec_next == '0) begin
                    res_fire        = 1'b1;
                    res_item.status = ST_ABSENT;
                    ram_raddr       = '0;
                end else begin
                    ram_raddr = dec_next;
                end
            end
            S_DEC_LEAF: begin
                if (is_leaf) begin
                    res_fire                = 1'b1;
                    res_item.decoded_symbol = rd_node.symbol;
                    res_item.status         = ST_OK;
                    res_item.stream_done    = last_symbol;
                    ram_raddr               = '0;
                end else begin
                    // re-read the inner node so its data is there for the next bit
                    ram_raddr = r_cur;
                end
            end
            S_DEC_FLUSH: begin
                ram_raddr = r_cur;
            end
            default: begin
                ram_raddr = r_cur;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_node     = r_node;
        n_pos      = r_pos;
        n_code     = r_code;
        n_sym      = r_sym;
        n_byte     = r_byte;
        n_bit      = r_bit;
        n_cur      = r_cur;
        n_free     = r_free;
        n_left     = r_left;
        n_expected = r_expected;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_out      = r_out;
        n_out_vld  = 1'b0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_expected = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.opcode)
                        OP_LOAD: begin
                            n_node = '0;
                            n_pos  = POS_W'(i_item.code_length - 6'd1);
                            n_code = i_item.code_value;
                            n_sym  = i_item.entry_symbol;
                        end
                        OP_DATA: begin
                            n_byte = i_item.data_byte;
                            n_bit  = 3'd7;
                        end
                        OP_CLEAR: begin
                            n_cur  = '0;
                            n_free = FREE_W'(1);
                            n_left = r_expected;
                        end
                        default: begin
                            n_node = r_node;
                        end
                    endcase
                end
            end
            S_LD_CHK: begin
                if (ld_follow) begin
                    n_node = ld_slot;
                    n_pos  = r_pos - POS_W'(1);
                end else if (!mem_full) begin
                    n_free = r_free + FREE_W'(1);
                    n_node = free_addr;
                    if (r_pos != '0) begin
                        n_pos = r_pos - POS_W'(1);
                    end
                end
            end
            S_DEC_CHK: begin
                n_cur = dec_next;
                if (dec_next == '0) begin
                    n_bit = r_bit - 3'd1;
                end
            end
            S_DEC_LEAF: begin
                n_bit = r_bit - 3'd1;
                if (is_leaf) begin
                    n_cur  = '0;
                    n_left = r_left - CNT_W'(1);
                end
            end
            default: begin
                n_node = r_node;
            end
        endcase

        // result path: a new result releases the held one, flush releases it as last
        if (rej_fire) begin
            n_out_vld          = 1'b1;
            n_out              = '0;
            n_out.status       = ST_REJECT;
            n_out.last         = 1'b1;
        end
        if (res_fire) begin
            if (r_pend_vld) begin
                n_out_vld = 1'b1;
                n_out     = r_pend;
            end
            n_pend     = res_item;
            n_pend_vld = 1'b1;
        end
        if (r_state == S_DEC_FLUSH) begin
            if (r_pend_vld) begin
                n_out_vld  = 1'b1;
                n_out      = r_pend;
                n_out.last = 1'b1;
            end
            n_pend_vld = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_cur      <= '0;
            r_free     <= FREE_W'(1);
            r_left     <= '0;
            r_expected <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur      <= n_cur;
            r_free     <= n_free;
            r_left     <= n_left;
            r_expected <= n_expected;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_pos  <= n_pos;
        r_code <= n_code;
        r_sym  <= n_sym;
        r_byte <= n_byte;
        r_bit  <= n_bit;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_res_strobe = r_out_vld;
    assign o_result     = r_out;

endmodule
